// ----- sv/path_segment_interpolator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Path segment interpolator assertion macros
// Shared concurrent assertion forms for the interpolator top level.
// ----------------------------------------------------------------------------
`ifndef PATH_SEGMENT_INTERPOLATOR_UNIT_ASSERT_SVH
`define PATH_SEGMENT_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PSI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/psi_pkg.sv -----
// ----------------------------------------------------------------------------
// psi_pkg
// Shared constants, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package psi_pkg;

   localparam int unsigned MAX_SEG_PTS  = 63;
   localparam int unsigned PPM_W        = 10;
   localparam logic [9:0]  PPM_RESET    = 10'd20;
   localparam int unsigned COORD_W      = 32;
   localparam int unsigned SEQ_W        = 16;
   localparam int unsigned ITER_STEPS   = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQRT,
      ST_SCALE,
      ST_NSEL,
      ST_DIV,
      ST_EMIT
   } psi_state_type;

   typedef struct packed {
      logic accept;
      logic sq_x;
      logic sq_y;
      logic sqrt_step;
      logic scale;
      logic nsel;
      logic div_step;
      logic advance;
      logic load_final;
      logic out_fire;
   } psi_cmd_type;

   typedef struct packed {
      logic have_prev;
      logic fin;
   } psi_status_type;

endpackage

`default_nettype wire

// ----- sv/psi_datapath.sv -----
// ----------------------------------------------------------------------------
// psi_datapath
// Delta, sum of squares, iterative square root, point count, iterative
// divider and incremental point stepping for one segment.
// ----------------------------------------------------------------------------
`default_nettype none

module psi_datapath #(
   parameter int unsigned MAX_SEGMENT_POINTS = psi_pkg::MAX_SEG_PTS,
   parameter int unsigned NW = $clog2(MAX_SEGMENT_POINTS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psi_pkg::psi_cmd_type          cmd,
   input  wire logic signed [31:0]            req_pos_x,
   input  wire logic signed [31:0]            req_pos_y,
   input  wire logic                          req_is_final,
   input  wire logic                          csr_wr,
   input  wire logic [9:0]                    csr_points_per_meter,
   output      psi_pkg::psi_status_type       status,
   output      logic [NW-1:0]                 seg_n,
   output      logic signed [31:0]            rsp_out_x,
   output      logic signed [31:0]            rsp_out_y,
   output      logic [15:0]                   rsp_seq_index
);
   import psi_pkg::*;

   localparam logic [NW-1:0] NMAX = NW'(MAX_SEGMENT_POINTS);

   logic [9:0]  ppm_ff;
   logic [31:0] prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff;
   logic        have_prev_ff, fin_ff;
   logic [15:0] seq_ff;
   logic [31:0] pt_x_ff, pt_y_ff;
   logic [31:0] ax_ff, ay_ff;
   logic        sx_ff, sy_ff;
   logic [63:0] sqx_ff, rad_ff;
   logic [33:0] srem_ff;
   logic [31:0] root_ff;
   logic [41:0] prod_ff;
   logic [NW-1:0] n_ff;
   logic [31:0] qx_ff, qy_ff;
   logic [NW-1:0] dvx_ff, dvy_ff, accx_ff, accy_ff;

   logic signed [32:0] dx, dy;
   logic [32:0] mdx, mdy;
   logic [33:0] srem_sh, strial;
   logic [NW:0] dvx_sh, dvy_sh, accx_sum, accy_sum;
   logic [25:0] n_raw;
   logic [NW-1:0] n_in;
   logic [31:0] stepx, stepy;
   logic        cx, cy;

   always_comb begin
      dx  = 33'($signed(req_pos_x)) - 33'($signed(prev_x_ff));
      dy  = 33'($signed(req_pos_y)) - 33'($signed(prev_y_ff));
      mdx = dx[32] ? -dx : dx;
      mdy = dy[32] ? -dy : dy;
      srem_sh = {srem_ff[31:0], rad_ff[63:62]};
      strial  = {root_ff, 2'b01};
      n_raw   = prod_ff[41:16];
      if (ppm_ff == '0) begin
         n_in = '0;
      end else if (ax_ff[31] || ay_ff[31]) begin
         n_in = NMAX;
      end else if (n_raw > 26'(MAX_SEGMENT_POINTS)) begin
         n_in = NMAX;
      end else begin
         n_in = n_raw[NW-1:0];
      end
      dvx_sh = {dvx_ff, qx_ff[31]};
      dvy_sh = {dvy_ff, qy_ff[31]};
      accx_sum = {1'b0, accx_ff} + {1'b0, dvx_ff};
      accy_sum = {1'b0, accy_ff} + {1'b0, dvy_ff};
      cx = accx_sum >= {1'b0, n_ff};
      cy = accy_sum >= {1'b0, n_ff};
      stepx = qx_ff + 32'(cx);
      stepy = qy_ff + 32'(cy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff       <= PPM_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         if (csr_wr) begin
            ppm_ff <= csr_points_per_meter;
         end
         if (cmd.accept) begin
            prev_x_ff    <= req_pos_x;
            prev_y_ff    <= req_pos_y;
            have_prev_ff <= !req_is_final;
         end
         if (cmd.out_fire) begin
            seq_ff <= seq_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_x_ff <= req_pos_x;
         cur_y_ff <= req_pos_y;
         fin_ff   <= req_is_final;
         pt_x_ff  <= have_prev_ff ? prev_x_ff : req_pos_x;
         pt_y_ff  <= have_prev_ff ? prev_y_ff : req_pos_y;
         ax_ff    <= mdx[31:0];
         ay_ff    <= mdy[31:0];
         sx_ff    <= dx[32];
         sy_ff    <= dy[32];
      end
      if (cmd.sq_x) begin
         sqx_ff <= ax_ff * ax_ff;
      end
      if (cmd.sq_y) begin
         rad_ff  <= sqx_ff + ay_ff * ay_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[61:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sh - strial;
            root_ff <= {root_ff[30:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[30:0], 1'b0};
         end
      end
      if (cmd.scale) begin
         prod_ff <= root_ff * ppm_ff;
      end
      if (cmd.nsel) begin
         n_ff    <= n_in;
         qx_ff   <= ax_ff;
         qy_ff   <= ay_ff;
         dvx_ff  <= '0;
         dvy_ff  <= '0;
         accx_ff <= '0;
         accy_ff <= '0;
      end
      if (cmd.div_step) begin
         if (dvx_sh >= {1'b0, n_ff}) begin
            dvx_ff <= NW'(dvx_sh - {1'b0, n_ff});
            qx_ff  <= {qx_ff[30:0], 1'b1};
         end else begin
            dvx_ff <= dvx_sh[NW-1:0];
            qx_ff  <= {qx_ff[30:0], 1'b0};
         end
         if (dvy_sh >= {1'b0, n_ff}) begin
            dvy_ff <= NW'(dvy_sh - {1'b0, n_ff});
            qy_ff  <= {qy_ff[30:0], 1'b1};
         end else begin
            dvy_ff <= dvy_sh[NW-1:0];
            qy_ff  <= {qy_ff[30:0], 1'b0};
         end
      end
      if (cmd.advance) begin
         accx_ff <= cx ? NW'(accx_sum - {1'b0, n_ff}) : accx_sum[NW-1:0];
         accy_ff <= cy ? NW'(accy_sum - {1'b0, n_ff}) : accy_sum[NW-1:0];
         pt_x_ff <= sx_ff ? pt_x_ff - stepx : pt_x_ff + stepx;
         pt_y_ff <= sy_ff ? pt_y_ff - stepy : pt_y_ff + stepy;
      end
      if (cmd.load_final) begin
         pt_x_ff <= cur_x_ff;
         pt_y_ff <= cur_y_ff;
      end
   end

   assign status.have_prev = have_prev_ff;
   assign status.fin       = fin_ff;
   assign seg_n            = n_ff;
   assign rsp_out_x        = pt_x_ff;
   assign rsp_out_y        = pt_y_ff;
   assign rsp_seq_index    = seq_ff;

endmodule

`default_nettype wire

// ----- sv/psi_controller.sv -----
// ----------------------------------------------------------------------------
// psi_controller
// Sequences one waypoint: squares, root, count, divide, then point emission.
// ----------------------------------------------------------------------------
`default_nettype none

module psi_controller #(
   parameter int unsigned NW = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_is_final,
   input  wire logic                     rsp_ready,
   input  wire psi_pkg::psi_status_type  status,
   input  wire logic [NW-1:0]            seg_n,
   output      psi_pkg::psi_cmd_type     cmd,
   output      logic                     req_ready,
   output      logic                     rsp_valid,
   output      logic                     rsp_end_of_run
);
   import psi_pkg::*;

   psi_state_type state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [NW-1:0] j_ff, j_in;
   logic          last_pt_ff, last_pt_in;
   logic [NW-1:0] last_j;
   logic          seg_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         j_ff       <= '0;
         last_pt_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         j_ff       <= j_in;
         last_pt_ff <= last_pt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      j_in           = j_ff;
      last_pt_in     = last_pt_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_end_of_run = 1'b0;
      last_j         = (seg_n < NW'(2)) ? '0 : seg_n - NW'(1);
      seg_last       = (j_ff == last_j);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.have_prev) begin
                  state_in = ST_SQX;
               end else if (req_is_final) begin
                  last_pt_in = 1'b1;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ITER_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_NSEL;
         end
         ST_NSEL: begin
            cmd.nsel = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ITER_STEPS - 1)) begin
               j_in       = '0;
               last_pt_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid      = 1'b1;
            rsp_end_of_run = last_pt_ff || (seg_last && !status.fin);
            if (rsp_ready) begin
               cmd.out_fire = 1'b1;
               if (last_pt_ff) begin
                  last_pt_in = 1'b0;
                  state_in   = ST_IDLE;
               end else if (seg_last) begin
                  if (status.fin) begin
                     cmd.load_final = 1'b1;
                     last_pt_in     = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.advance = 1'b1;
                  j_in        = j_ff + NW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/path_segment_interpolator_unit.sv -----
// The first point is offered once the square root and the divider finish,
// then one point per cycle while rsp_ready stays high.
// The 32-step square root and the 32-step divider share one sequencer.
// A final-only waypoint goes straight to emitting its point.
// Synchronous active-high reset: idle, no previous waypoint, sequence 0,
// points_per_meter 20.
// ----------------------------------------------------------------------------
// path_segment_interpolator_unit
// Emits linearly interpolated points along each segment between waypoints.
// ----------------------------------------------------------------------------
`default_nettype none

module path_segment_interpolator_unit #(
   parameter int unsigned MAX_SEGMENT_POINTS = psi_pkg::MAX_SEG_PTS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic               req_is_final,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_out_x,
   output      logic signed [31:0] rsp_out_y,
   output      logic [15:0]        rsp_seq_index,
   output      logic               rsp_end_of_run,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [9:0]         csr_points_per_meter
);
   import psi_pkg::*;

`include "path_segment_interpolator_unit_assert.svh"

   localparam int unsigned NW = $clog2(MAX_SEGMENT_POINTS + 1);

   psi_cmd_type    cmd;
   psi_status_type status;
   logic [NW-1:0]  seg_n;

   assign csr_ready = req_ready;

   psi_controller #(.NW(NW)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_is_final   (req_is_final),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .seg_n          (seg_n),
      .cmd            (cmd),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_end_of_run (rsp_end_of_run)
   );

   psi_datapath #(.MAX_SEGMENT_POINTS(MAX_SEGMENT_POINTS), .NW(NW)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_is_final         (req_is_final),
      .csr_wr               (csr_valid && csr_ready),
      .csr_points_per_meter (csr_points_per_meter),
      .status               (status),
      .seg_n                (seg_n),
      .rsp_out_x            (rsp_out_x),
      .rsp_out_y            (rsp_out_y),
      .rsp_seq_index        (rsp_seq_index)
   );

   `PSI_ASSERT_NOW(a_idle_no_rsp, clock, reset, req_ready, !rsp_valid,
      "result offered while idle")
   `PSI_ASSERT_NEXT(a_run_end_idle, clock, reset,
      rsp_valid && rsp_ready && rsp_end_of_run, req_ready,
      "not idle after last result")
   `PSI_ASSERT_NEXT(a_seq_step, clock, reset, rsp_valid && rsp_ready,
      rsp_seq_index == 16'($past(rsp_seq_index) + 16'd1),
      "sequence number did not advance by one")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path segment interpolator testbench
// Drives waypoint paths with random handshake gaps, predicts every emitted
// point (segment starts, interior points, finals) and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

class point_scoreboard;
   logic [9:0]         ppm;
   logic signed [31:0] last_x, last_y;
   bit                 path_open;
   logic [15:0]        seq;
   logic [80:0]        pending[$];
   int                 mismatches;
   int                 points_seen;

   function void clear();
      ppm = psi_pkg::PPM_RESET;
      last_x = 0; last_y = 0; path_open = 0; seq = 16'd0;
      pending.delete(); mismatches = 0; points_seen = 0;
   endfunction

   function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0; b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function int seg_points(longint dx, longint dy);
      longint ax, ay;
      logic [63:0] l, n;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ppm == 0) return 0;
      if (ax >= 64'sh80000000 || ay >= 64'sh80000000) return psi_pkg::MAX_SEG_PTS;
      l = isqrt(ax * ax + ay * ay);
      n = (l * ppm) >> 16;
      if (n > psi_pkg::MAX_SEG_PTS) n = psi_pkg::MAX_SEG_PTS;
      return int'(n);
   endfunction

   function void push_point(longint x, longint y);
      pending.insert(pending.size(), {x[31:0], y[31:0], seq, 1'b0});
      seq = seq + 16'd1;
   endfunction

   function void note_waypoint(logic signed [31:0] x, logic signed [31:0] y, bit fin);
      longint x1, y1, dx, dy;
      int n, prior_size;
      prior_size = pending.size();
      if (path_open) begin
         x1 = last_x; y1 = last_y;
         dx = longint'(x) - x1; dy = longint'(y) - y1;
         n = seg_points(dx, dy);
         push_point(x1, y1);
         for (int j = 1; j < n; j++)
            push_point(x1 + (j * dx) / n, y1 + (j * dy) / n);
      end
      if (fin) push_point(x, y);
      path_open = !fin;
      last_x = x; last_y = y;
      if (pending.size() > prior_size) pending[pending.size() - 1][0] = 1'b1;
   endfunction

   function void check_point(logic [31:0] x, logic [31:0] y, logic [15:0] s, logic e);
      logic [80:0] exp_pt;
      points_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected point x=%h y=%h seq=%0d", x, y, s);
         return;
      end
      exp_pt = pending.pop_front();
      if (exp_pt != {x, y, s, e}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h seq=%0d end=%b got x=%h y=%h seq=%0d end=%b",
                     exp_pt[80:49], exp_pt[48:17], exp_pt[16:1], exp_pt[0], x, y, s, e);
      end
   endfunction
endclass

module tb;
   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0, req_is_final = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0;
   logic [9:0] csr_points_per_meter = 0;
   wire req_ready, rsp_valid, rsp_end_of_run, csr_ready;
   wire signed [31:0] rsp_out_x, rsp_out_y;
   wire [15:0] rsp_seq_index;

   point_scoreboard sb = new();
   int idle_cycles = 0;
   int waypoints = 0;
   bit rsp_hold = 0;

   path_segment_interpolator_unit u_dut (.*);

   initial forever #1 clock = ~clock;

   function int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_point(rsp_out_x, rsp_out_y, rsp_seq_index, rsp_end_of_run);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stalls; phases with no stalls
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ready <= 1;
         end else begin
            g = gap_len();
            if (g != 0) begin
               rsp_ready <= 0;
               repeat (g) @(posedge clock);
            end
            rsp_ready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_waypoint(logic signed [31:0] x, logic signed [31:0] y, bit fin);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1; req_pos_x <= x; req_pos_y <= y; req_is_final <= fin;
      do @(posedge clock); while (!req_ready);
      sb.note_waypoint(x, y, fin);
      waypoints++;
   endtask

   task automatic write_ppm(logic [9:0] v);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_valid <= 1; csr_points_per_meter <= v;
      do @(posedge clock); while (!csr_ready);
      sb.ppm = v;
      csr_valid <= 0;
   endtask

   // nearby point: mostly short steps so n stays small
   function logic signed [31:0] near(logic signed [31:0] c);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return c + $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
   endfunction

   initial begin
      logic signed [31:0] x, y;
      sb.clear();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_waypoint(0, 0, 1);
      send_waypoint(32'sh7fffffff, 32'sh80000000, 0);
      send_waypoint(32'sh80000000, 32'sh7fffffff, 0);
      send_waypoint(32'sh80000000, 32'sh7fffffff, 0);
      send_waypoint(32'sh00010000, 32'sh00020000, 0);
      send_waypoint(32'sh00018000, 32'sh00020000, 0);
      send_waypoint(32'sh00018100, 32'sh00020000, 1);
      send_waypoint(32'sh00030000, 32'shfffd0000, 0);
      send_waypoint(32'sh7fffffff, 32'sh7fffffff, 1);
      write_ppm(10'd0);
      send_waypoint(32'sh00100000, 0, 0);
      send_waypoint(32'sh80000000, 32'sh80000000, 0);
      send_waypoint(0, 32'shffffffff, 1);
      write_ppm(10'd1000);
      send_waypoint(0, 0, 0);
      send_waypoint(32'sh00000100, 32'sh00000080, 0);
      send_waypoint(32'shfffff000, 0, 1);
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: write_ppm(10'd1);
            1: write_ppm(10'h3ff);
            2: write_ppm(10'd20);
            default: write_ppm(10'($urandom_range(0, 1023)));
         endcase
         rsp_hold = (p == 2);
         x = $urandom; y = $urandom;
         for (int i = 0; i < 45; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               x = $urandom; y = $urandom;
            end else begin
               x = near(x); y = near(y);
            end
            send_waypoint(x, y, $urandom_range(0, 7) == 0);
         end
         send_waypoint(near(x), near(y), 1);
      end
      req_valid <= 0;
      rsp_hold = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d waypoints, %0d points checked, ppm settings 0..1023",
               waypoints, sb.points_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("FAILURE");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/psi_pkg.sv
sv/psi_datapath.sv
sv/psi_controller.sv
sv/path_segment_interpolator_unit.sv
tb/sv/tb.sv
